// ===== rtl/oarb_pkg.sv =====
// Shared constants and types for the overlap-add ring buffer.
// Used by oarb_ring, the top level overlap_add_ring_buffer and its checker.
package oarb_pkg;

	localparam int unsigned DEPTH    = 1024;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);
	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned SIZE_W   = 11;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic CFG_BUFFER_SIZE = 1'b0;
	localparam logic CFG_HOP_SIZE    = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	typedef struct packed {
		logic                       valid;
		logic                       op;
		logic [ADDR_W-1:0]          addr;
		logic signed [SAMPLE_W-1:0] sample;
	} ring_req_t;

	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] data;
	} ring_res_t;

	typedef struct packed {
		logic busy;
		logic pend_read;
	} ring_stat_t;

endpackage

// ===== rtl/oarb_ring.sv =====
// Ring memory with read-modify-write: saturating accumulate or read-and-clear.
// Holds the clearing pass after reset. Depends on oarb_pkg.
module oarb_ring (
	input  logic                   clk,
	input  logic                   arst_n,
	input  oarb_pkg::ring_req_t    req,
	output oarb_pkg::ring_res_t    res,
	output oarb_pkg::ring_stat_t   stat
);

	logic signed [oarb_pkg::SAMPLE_W-1:0] mem [oarb_pkg::DEPTH];
	logic signed [oarb_pkg::SAMPLE_W-1:0] rdata_s1;
	logic signed [oarb_pkg::SAMPLE_W-1:0] fwd_data_s1;
	logic                                 fwd_hit_s1;
	logic                                 valid_s1;
	logic                                 op_s1;
	logic [oarb_pkg::ADDR_W-1:0]          addr_s1;
	logic signed [oarb_pkg::SAMPLE_W-1:0] sample_s1;

	logic                                 clr_active_q;
	logic [oarb_pkg::ADDR_W-1:0]          clr_addr_q;

	logic signed [oarb_pkg::SAMPLE_W-1:0] old_c;
	logic signed [oarb_pkg::SAMPLE_W:0]   sum_c;
	logic signed [oarb_pkg::SAMPLE_W-1:0] wdata_c;
	logic                                 we_c;
	logic [oarb_pkg::ADDR_W-1:0]          waddr_c;
	logic signed [oarb_pkg::SAMPLE_W-1:0] mem_wdata_c;

	// the entry the previous request wrote to the same address is newer than what memory returned
	assign old_c = fwd_hit_s1 ? fwd_data_s1 : rdata_s1;
	assign sum_c = {old_c[oarb_pkg::SAMPLE_W-1], old_c}
		+ {sample_s1[oarb_pkg::SAMPLE_W-1], sample_s1};

	always_comb begin
		if (op_s1 == oarb_pkg::OP_READ) begin
			wdata_c = '0;
		end else if (sum_c[oarb_pkg::SAMPLE_W] != sum_c[oarb_pkg::SAMPLE_W-1]) begin
			// saturate toward the sign of the true sum
			wdata_c = sum_c[oarb_pkg::SAMPLE_W]
				? {1'b1, {(oarb_pkg::SAMPLE_W-1){1'b0}}}
				: {1'b0, {(oarb_pkg::SAMPLE_W-1){1'b1}}};
		end else begin
			wdata_c = sum_c[oarb_pkg::SAMPLE_W-1:0];
		end
	end

	assign we_c        = clr_active_q || valid_s1;
	assign waddr_c     = clr_active_q ? clr_addr_q : addr_s1;
	assign mem_wdata_c = clr_active_q ? '0 : wdata_c;

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= mem_wdata_c;
		end
		if (req.valid) begin
			rdata_s1 <= mem[req.addr];
		end
	end

	always_ff @(posedge clk) begin
		op_s1       <= req.op;
		addr_s1     <= req.addr;
		sample_s1   <= req.sample;
		fwd_data_s1 <= wdata_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			valid_s1   <= req.valid;
			fwd_hit_s1 <= req.valid && valid_s1 && (addr_s1 == req.addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == oarb_pkg::ADDR_W'(oarb_pkg::DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	assign res.valid      = valid_s1 && (op_s1 == oarb_pkg::OP_READ);
	assign res.data       = old_c;
	assign stat.busy      = clr_active_q;
	assign stat.pend_read = valid_s1 && (op_s1 == oarb_pkg::OP_READ);

endmodule

// ===== rtl/overlap_add_ring_buffer.sv =====
// Overlap-add output buffer: one request per cycle while s_tready is high, write requests
// accumulate with saturation, read requests return and clear one entry. Depends on oarb_pkg
// and oarb_ring. Throughput is one request per clock while s_tready is high, write or read,
// set by the single-port-read, single-port-write ring memory whose read-modify-write
// completes in the cycle after the request; a read result passes through the ring's s1
// stage into a four-entry output queue, from which it is shown on m_tdata; s_tready drops
// while three or more results are queued or still in the ring pipeline. After reset the
// block runs a clearing pass over all 1024 ring entries, during which s_tready stays low;
// configuration writes are taken at any time and should only be issued while the block is
// idle.
module overlap_add_ring_buffer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [oarb_pkg::SAMPLE_W-1:0] s_tdata,  // [23:0] sample_in
	input  logic                          s_tuser,  // [0] op
	input  logic                          s_tlast,  // block_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [oarb_pkg::SAMPLE_W-1:0] m_tdata,  // [23:0] sample_out
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [oarb_pkg::SIZE_W-1:0]   cfg_data
);

	logic [oarb_pkg::SIZE_W-1:0] buffer_size_q;
	logic [oarb_pkg::SIZE_W-1:0] hop_size_q;
	logic [oarb_pkg::ADDR_W-1:0] base_q;
	logic [oarb_pkg::ADDR_W-1:0] off_q;
	logic [oarb_pkg::ADDR_W-1:0] rd_q;

	logic [oarb_pkg::SIZE_W-1:0] n_c;
	logic [oarb_pkg::ADDR_W-1:0] base_c;
	logic [oarb_pkg::ADDR_W-1:0] off_c;
	logic [oarb_pkg::ADDR_W-1:0] rd_c;
	logic [oarb_pkg::SIZE_W-1:0] pos_sum_c;
	logic [oarb_pkg::SIZE_W-1:0] pos_c;
	logic [oarb_pkg::SIZE_W-1:0] off_inc_c;
	logic [oarb_pkg::SIZE_W-1:0] rd_inc_c;
	logic [oarb_pkg::SIZE_W:0]   base_next_c;
	logic [oarb_pkg::ADDR_W-1:0] off_nx_c;
	logic [oarb_pkg::ADDR_W-1:0] rd_nx_c;
	logic                        accept_c;

	oarb_pkg::ring_req_t  req;
	oarb_pkg::ring_res_t  res;
	oarb_pkg::ring_stat_t stat;

	logic [oarb_pkg::SAMPLE_W-1:0] fifo_q [4];
	logic [1:0]                    wr_ptr_q;
	logic [1:0]                    rd_ptr_q;
	logic [2:0]                    count_q;
	logic                          pop_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= oarb_pkg::SIZE_RESET;
			hop_size_q    <= oarb_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				oarb_pkg::CFG_BUFFER_SIZE: buffer_size_q <= cfg_data;
				oarb_pkg::CFG_HOP_SIZE:    hop_size_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// active ring size, clamped to [1, DEPTH]
	always_comb begin
		if (buffer_size_q == '0) begin
			n_c = oarb_pkg::SIZE_W'(1);
		end else if (buffer_size_q > oarb_pkg::SIZE_W'(oarb_pkg::DEPTH)) begin
			n_c = oarb_pkg::SIZE_W'(oarb_pkg::DEPTH);
		end else begin
			n_c = buffer_size_q;
		end
	end

	// pointers past a shrunken ring restart at zero
	assign base_c = (oarb_pkg::SIZE_W'(base_q) >= n_c) ? '0 : base_q;
	assign off_c  = (oarb_pkg::SIZE_W'(off_q)  >= n_c) ? '0 : off_q;
	assign rd_c   = (oarb_pkg::SIZE_W'(rd_q)   >= n_c) ? '0 : rd_q;

	assign pos_sum_c = oarb_pkg::SIZE_W'(base_c) + oarb_pkg::SIZE_W'(off_c);
	assign pos_c     = (pos_sum_c >= n_c) ? pos_sum_c - n_c : pos_sum_c;

	assign off_inc_c = oarb_pkg::SIZE_W'(off_c) + oarb_pkg::SIZE_W'(1);
	assign off_nx_c  = (off_inc_c >= n_c) ? '0 : off_inc_c[oarb_pkg::ADDR_W-1:0];
	assign rd_inc_c  = oarb_pkg::SIZE_W'(rd_c) + oarb_pkg::SIZE_W'(1);
	assign rd_nx_c   = (rd_inc_c >= n_c) ? '0 : rd_inc_c[oarb_pkg::ADDR_W-1:0];
	assign base_next_c = (oarb_pkg::SIZE_W+1)'(base_c) + {1'b0, hop_size_q};

	// leave room in the queue for a read still in the ring pipeline
	assign s_tready = !stat.busy && ((count_q + {2'b00, stat.pend_read}) <= 3'd2);
	assign accept_c = s_tvalid && s_tready;

	// every request stores all three pointers back in range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			off_q  <= '0;
			rd_q   <= '0;
		end else if (accept_c) begin
			if (s_tuser == oarb_pkg::OP_READ) begin
				base_q <= base_c;
				off_q  <= off_c;
				rd_q   <= rd_nx_c;
			end else if (s_tlast) begin
				base_q <= (base_next_c >= {1'b0, n_c})
					? '0 : base_next_c[oarb_pkg::ADDR_W-1:0];
				off_q  <= '0;
				rd_q   <= rd_c;
			end else begin
				base_q <= base_c;
				off_q  <= off_nx_c;
				rd_q   <= rd_c;
			end
		end
	end

	always_comb begin
		req.valid  = accept_c;
		req.op     = s_tuser;
		req.addr   = (s_tuser == oarb_pkg::OP_READ) ? rd_c : pos_c[oarb_pkg::ADDR_W-1:0];
		req.sample = s_tdata;
	end

	oarb_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.stat   (stat)
	);

	assign m_tvalid = (count_q != 3'd0);
	assign m_tdata  = fifo_q[rd_ptr_q];
	assign pop_c    = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (res.valid) begin
			fifo_q[wr_ptr_q] <= res.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_c) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {2'b00, res.valid} - {2'b00, pop_c};
		end
	end

endmodule

// ===== rtl/oarb_checker.sv =====
// Port-level checks for overlap_add_ring_buffer, bound to the top level.
// Depends on oarb_pkg.
module oarb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [oarb_pkg::SAMPLE_W-1:0] m_tdata,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// a new result comes from an accepted read request, through the ring stage and the queue
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == oarb_pkg::OP_READ), 2))
		else $error("result without a read request");

	// the ring is being cleared right after reset
	a_clear_after_reset: assert property (@(posedge clk)
		!arst_n |=> !s_tready)
		else $error("request taken during clearing pass");

	a_cfg_always: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind overlap_add_ring_buffer oarb_checker u_oarb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// ===== tb/overlap_add_ring_buffer_test.sv =====
// Self-checking testbench for overlap_add_ring_buffer: a directed table, then random blocks
// and reads, checked against a local ring model or typed table values. Depends on oarb_pkg and the RTL.
module overlap_add_ring_buffer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 5;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 100;
	localparam int N_ROWS        = 34;
	localparam int SHOW_FAULTS   = 10;

	localparam logic signed [oarb_pkg::SAMPLE_W-1:0] SMAX =
		{1'b0, {(oarb_pkg::SAMPLE_W-1){1'b1}}};
	localparam logic signed [oarb_pkg::SAMPLE_W-1:0] SMIN =
		{1'b1, {(oarb_pkg::SAMPLE_W-1){1'b0}}};

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// sel is the op on ROW_ITEM and the register index on ROW_REG
	typedef struct packed {
		row_kind_t                            kind;
		logic                                 sel;
		logic signed [oarb_pkg::SAMPLE_W-1:0] sample;
		logic                                 blk;
		logic [oarb_pkg::SIZE_W-1:0]          value;
		logic                                 typed;
		logic signed [oarb_pkg::SAMPLE_W-1:0] want;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [oarb_pkg::SAMPLE_W-1:0] s_tdata;   // [23:0] sample_in
	logic                          s_tuser;   // [0] op
	logic                          s_tlast;   // block_end
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [oarb_pkg::SAMPLE_W-1:0] m_tdata;   // [23:0] sample_out
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_index;
	logic [oarb_pkg::SIZE_W-1:0]   cfg_data;

	// local image of the ring and its pointers
	logic signed [oarb_pkg::SAMPLE_W-1:0] ring_img [oarb_pkg::DEPTH];
	int unsigned                          wr_base;
	int unsigned                          wr_off;
	int unsigned                          rd_idx;
	logic [oarb_pkg::SIZE_W-1:0]          cur_size;
	logic [oarb_pkg::SIZE_W-1:0]          cur_hop;

	logic signed [oarb_pkg::SAMPLE_W-1:0] pending_samples [$];

	bit no_gaps = 1'b0;
	int faults  = 0;
	int n_writes, n_reads, n_settings, n_checked;
	int quiet = 0;

	dir_row_t dir_rows [0:N_ROWS-1] = '{
		// reset state, default 64/64: hop reaching the end returns base to 0
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b1, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, SMAX,   1'b1, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, SMAX,   1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_REG,  oarb_pkg::CFG_BUFFER_SIZE, 24'sd0, 1'b0, 11'd4, 1'b0, 24'sd0},
		'{ROW_REG,  oarb_pkg::CFG_HOP_SIZE,    24'sd0, 1'b0, 11'd1, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		// entry 0 saturated high by the two full-scale writes
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b1, SMAX},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, SMIN,   1'b1, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, SMIN,   1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b1, SMIN},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, -24'sd1, 1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, 24'sd1,  1'b0, 11'd0, 1'b0, 24'sd0},
		// base plus offset wraps past the end, then the offset wraps too
		'{ROW_ITEM, oarb_pkg::OP_WRITE, 24'sd7,  1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, 24'sd2,  1'b1, 11'd0, 1'b0, 24'sd0},
		// zero hop keeps the base in place
		'{ROW_REG,  oarb_pkg::CFG_HOP_SIZE,    24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, 24'sd3,  1'b1, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		// zero size acts as one entry, hop beyond the end
		'{ROW_REG,  oarb_pkg::CFG_BUFFER_SIZE, 24'sd0, 1'b0, 11'd0,    1'b0, 24'sd0},
		'{ROW_REG,  oarb_pkg::CFG_HOP_SIZE,    24'sd0, 1'b0, 11'd2047, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, SMAX,   1'b1, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, 24'sd9,  1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b1, SMAX},
		// size above the depth acts as the full ring
		'{ROW_REG,  oarb_pkg::CFG_BUFFER_SIZE, 24'sd0, 1'b0, 11'd2047, 1'b0, 24'sd0},
		'{ROW_REG,  oarb_pkg::CFG_HOP_SIZE,    24'sd0, 1'b0, 11'd1024, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b1, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, -24'sd5, 1'b1, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_WRITE, 24'sd4,  1'b0, 11'd0, 1'b0, 24'sd0},
		// shrink the ring while the current pointers stay within it
		'{ROW_REG,  oarb_pkg::CFG_BUFFER_SIZE, 24'sd0, 1'b0, 11'd3, 1'b0, 24'sd0},
		'{ROW_REG,  oarb_pkg::CFG_HOP_SIZE,    24'sd0, 1'b0, 11'd2, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0},
		'{ROW_ITEM, oarb_pkg::OP_READ,  24'sd0, 1'b0, 11'd0, 1'b0, 24'sd0}
	};

	overlap_add_ring_buffer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	function automatic int unsigned ring_span(logic [oarb_pkg::SIZE_W-1:0] sz);
		if (sz == '0)
			return 1;
		if (int'(sz) > oarb_pkg::DEPTH)
			return oarb_pkg::DEPTH;
		return int'(sz);
	endfunction

	// Advance the ring image by one request; return 1 with the read sample on a read.
	function automatic bit ring_predict(input logic op,
	                                    input logic signed [oarb_pkg::SAMPLE_W-1:0] smp,
	                                    input logic blk,
	                                    output logic signed [oarb_pkg::SAMPLE_W-1:0] rd_val);
		int unsigned n;
		int unsigned pos;
		int unsigned nxt;
		longint      sum;
		n      = ring_span(cur_size);
		rd_val = '0;
		if (wr_base >= n) wr_base = 0;
		if (wr_off >= n) wr_off = 0;
		if (rd_idx >= n) rd_idx = 0;
		if (op == oarb_pkg::OP_WRITE) begin
			pos = wr_base + wr_off;
			if (pos >= n) pos -= n;
			sum = longint'(ring_img[pos]) + longint'(smp);
			if (sum > longint'(SMAX))
				ring_img[pos] = SMAX;
			else if (sum < longint'(SMIN))
				ring_img[pos] = SMIN;
			else
				ring_img[pos] = oarb_pkg::SAMPLE_W'(sum);
			wr_off++;
			if (wr_off >= n) wr_off = 0;
			if (blk) begin
				nxt     = wr_base + int'(cur_hop);
				wr_base = (nxt >= n) ? 0 : nxt;
				wr_off  = 0;
			end
			return 1'b0;
		end
		rd_val           = ring_img[rd_idx];
		ring_img[rd_idx] = '0;
		rd_idx++;
		if (rd_idx >= n) rd_idx = 0;
		return 1'b1;
	endfunction

	function automatic logic signed [oarb_pkg::SAMPLE_W-1:0] pick_sample();
		if ($urandom_range(0, 3) == 0)
			return oarb_pkg::SAMPLE_W'($urandom());
		return oarb_pkg::SAMPLE_W'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	task automatic note_fault(string what, logic [oarb_pkg::SAMPLE_W-1:0] want,
	                          logic [oarb_pkg::SAMPLE_W-1:0] got);
		faults++;
		if (faults <= SHOW_FAULTS)
			$display("%0t: %s: sample_out expected %0d got %0d", $realtime, what,
			         $signed(want), $signed(got));
	endtask

	task automatic send_item(logic op, logic signed [oarb_pkg::SAMPLE_W-1:0] smp, logic blk,
	                         bit typed = 1'b0,
	                         logic signed [oarb_pkg::SAMPLE_W-1:0] want = '0);
		logic signed [oarb_pkg::SAMPLE_W-1:0] rd_val;
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= smp;
		s_tlast  <= blk;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (ring_predict(op, smp, blk, rd_val)) begin
			pending_samples.push_back(typed ? want : rd_val);
			n_reads++;
		end else begin
			n_writes++;
		end
	endtask

	// Drop the request line, drain all results, then let the pipeline go quiet.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [oarb_pkg::SIZE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == oarb_pkg::CFG_BUFFER_SIZE)
			cur_size = val;
		else
			cur_hop = val;
		n_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		m_tready <= no_gaps || ($urandom_range(99) >= 11);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (pending_samples.size() == 0) begin
				note_fault("result with nothing pending", '0, m_tdata);
			end else begin
				if (m_tdata !== pending_samples[0])
					note_fault("mismatch", pending_samples[0], m_tdata);
				void'(pending_samples.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned sz;
		int unsigned span;
		int unsigned hop;
		int          items;
		int          len;
		int          reads;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = oarb_pkg::OP_WRITE;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = oarb_pkg::CFG_BUFFER_SIZE;
		cfg_data  = '0;
		foreach (ring_img[i])
			ring_img[i] = '0;
		wr_base    = 0;
		wr_off     = 0;
		rd_idx     = 0;
		cur_size   = oarb_pkg::SIZE_RESET;
		cur_hop    = oarb_pkg::SIZE_RESET;
		n_writes   = 0;
		n_reads    = 0;
		n_settings = 0;
		n_checked  = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(dir_rows[i].sel, dir_rows[i].value);
			end else begin
				send_item(dir_rows[i].sel, dir_rows[i].sample, dir_rows[i].blk,
				          dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case ($urandom_range(0, 9))
				0: sz = oarb_pkg::DEPTH;
				1: sz = 0;
				2: sz = $urandom_range(oarb_pkg::DEPTH + 1, 2047);
				3: sz = 1;
				4: sz = oarb_pkg::DEPTH - 1;
				default: sz = $urandom_range(2, 16);
			endcase
			span = ring_span(oarb_pkg::SIZE_W'(sz));
			case ($urandom_range(0, 5))
				0: hop = 0;
				1: hop = $urandom_range(0, 2047);
				2: hop = span;
				default: hop = $urandom_range(1, (span > 16) ? 16 : span);
			endcase
			no_gaps = (p == RAND_PHASES / 2);
			write_reg(oarb_pkg::CFG_BUFFER_SIZE, oarb_pkg::SIZE_W'(sz));
			write_reg(oarb_pkg::CFG_HOP_SIZE, oarb_pkg::SIZE_W'(hop));
			items = 0;
			while (items < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 8) begin
					// one overlapping block, then up to one hop of output (at most 12 reads, the block length for a zero hop)
					len   = $urandom_range(1, 12);
					reads = (hop == 0) ? len : ((hop > 12) ? 12 : hop);
					for (int k = 0; k < len; k++)
						send_item(oarb_pkg::OP_WRITE, pick_sample(), k == len - 1);
					for (int k = 0; k < reads; k++)
						send_item(oarb_pkg::OP_READ, pick_sample(), 1'($urandom_range(0, 1)));
					items += len + reads;
				end else begin
					len = $urandom_range(1, 4);
					for (int k = 0; k < len; k++)
						send_item($urandom_range(0, 1) ? oarb_pkg::OP_READ : oarb_pkg::OP_WRITE,
						          pick_sample(), 1'($urandom_range(0, 1)));
					items += len;
				end
			end
		end
		no_gaps = 1'b0;
		settle();

		$display("Accepted %0d writes and %0d reads across %0d register writes;",
		         n_writes, n_reads, n_settings);
		$display("checked %0d read results, %0d mismatches.", n_checked, faults);
		if (faults == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
